### rtl/rpq_pkg.sv
// ----------------------------------------------------------------------------
// rpq_pkg
// Shared constants, register map and types for the RGB palette quantizer.
// ----------------------------------------------------------------------------
package rpq_pkg;

    // Field widths
    localparam int COORD_W   = 12;
    localparam int COLOR_W   = 8;
    localparam int ROW_W     = 10;
    localparam int COL_W     = 11;
    localparam int IDX_W     = 12;
    localparam int CFG_LEV_W = 5;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    // Level count default and dither thresholds
    localparam int MAX_LEVELS_DEF = 16;
    localparam int LOW_EDGE       = 64;
    localparam int HIGH_EDGE      = 192;
    localparam int CHANNEL_MAX    = 255;

    // Register reset values
    localparam logic [CFG_LEV_W-1:0] RST_LEVELS  = 5'd6;
    localparam logic [IDX_W-1:0]     RST_BG_IDX  = 12'd0;
    localparam logic [COL_W-1:0]     RST_COLUMNS = 11'd80;
    localparam logic [ROW_W-1:0]     RST_ROWS    = 10'd24;

    // Register index (word address)
    typedef enum logic [1:0] {
        REG_LEVELS  = 2'd0,
        REG_BG_IDX  = 2'd1,
        REG_COLUMNS = 2'd2,
        REG_ROWS    = 2'd3
    } t_reg_idx;

    // Cell position that travels down the pipe beside the colour math
    typedef struct packed {
        logic             drawn;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_pos;

endpackage

### rtl/rpq_channel.sv
// ----------------------------------------------------------------------------
// rpq_channel
// Two-stage scale of one colour channel to L levels, with dither level pair.
// ----------------------------------------------------------------------------
module rpq_channel #(
    parameter int LVL_W = 4
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [rpq_pkg::COLOR_W-1:0] i_color,
    input  logic [LVL_W-1:0]            i_lev_m1,
    output logic [LVL_W-1:0]            o_lo,
    output logic [LVL_W-1:0]            o_hi
);

    localparam int SC_W  = rpq_pkg::COLOR_W + LVL_W;
    localparam int REM_W = rpq_pkg::COLOR_W + 1;

    logic [SC_W-1:0]  r_scaled;
    logic [LVL_W-1:0] r_lo;
    logic [LVL_W-1:0] r_hi;

    logic [LVL_W-1:0] q_est;
    logic [REM_W-1:0] rem_est;
    logic [LVL_W-1:0] q;
    logic [REM_W-1:0] rem;
    logic [LVL_W-1:0] q_up;
    logic [LVL_W-1:0] n_lo;
    logic [LVL_W-1:0] n_hi;

    // x/255: estimate with x>>8, remainder is low byte plus estimate,
    // one correction step since the estimate is never more than one short.
    always_comb begin
        q_est   = r_scaled[SC_W-1:rpq_pkg::COLOR_W];
        rem_est = {1'b0, r_scaled[rpq_pkg::COLOR_W-1:0]} + REM_W'(q_est);
        if (rem_est >= REM_W'(rpq_pkg::CHANNEL_MAX)) begin
            q   = q_est + LVL_W'(1);
            rem = rem_est - REM_W'(rpq_pkg::CHANNEL_MAX);
        end else begin
            q   = q_est;
            rem = rem_est;
        end
        q_up = q + LVL_W'(1);
        n_lo = (rem >= REM_W'(rpq_pkg::HIGH_EDGE)) ? q_up : q;
        n_hi = (rem >= REM_W'(rpq_pkg::LOW_EDGE))  ? q_up : q;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_scaled <= SC_W'(i_color) * SC_W'(i_lev_m1);
            r_lo     <= n_lo;
            r_hi     <= n_hi;
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

### rtl/rgb_palette_quantize_two_cell.sv
// ----------------------------------------------------------------------------
// rgb_palette_quantize_two_cell
// Pixel to two-cell palette index mapper with ordered level dither.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle; the whole pipe holds on output stall.
// Stages: scale+clip, divide by 255 + dither, index products, sum + swap.
// Reset: synchronous active low; clears valid bits and loads register
//   defaults (6 levels, background 0, 80 columns, 24 rows). No clearing pass.
// ----------------------------------------------------------------------------
module rgb_palette_quantize_two_cell #(
    parameter int MAX_LEVELS = rpq_pkg::MAX_LEVELS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // APB-style configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rpq_pkg::ADDR_W-1:0]   paddr,
    input  logic [rpq_pkg::DATA_W-1:0]   pwdata,
    output logic [rpq_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,

    // Pixel input channel
    input  logic                         i_pix_valid,
    output logic                         o_pix_stall,
    input  logic [rpq_pkg::COORD_W-1:0]  i_pixel_column,
    input  logic [rpq_pkg::COORD_W-1:0]  i_pixel_row,
    input  logic [rpq_pkg::COLOR_W-1:0]  i_red,
    input  logic [rpq_pkg::COLOR_W-1:0]  i_green,
    input  logic [rpq_pkg::COLOR_W-1:0]  i_blue,

    // Cell result channel
    output logic                         o_cell_valid,
    input  logic                         i_cell_stall,
    output logic                         o_drawn,
    output logic [rpq_pkg::ROW_W-1:0]    o_cell_row,
    output logic [rpq_pkg::COL_W-1:0]    o_left_cell_column,
    output logic [rpq_pkg::IDX_W-1:0]    o_left_index,
    output logic [rpq_pkg::IDX_W-1:0]    o_right_index
);

    // Level value width (0..MAX-1), level count width (up to MAX), L*L width
    localparam int LVL_W = $clog2(MAX_LEVELS);
    localparam int L_W   = $clog2(MAX_LEVELS + 1);
    localparam int SQ_W  = 2 * L_W;
    localparam int RP_W  = LVL_W + SQ_W;   // r * L * L
    localparam int GP_W  = LVL_W + L_W;    // g * L
    localparam int SUM_W = RP_W + 1;

    localparam int CW = rpq_pkg::CFG_LEV_W;

    // ------------------------------------------------------------------
    // Configuration registers. Derived level terms are loaded on the same
    // edge as the level register so a pixel right behind a write sees them.
    // ------------------------------------------------------------------
    logic [CW-1:0]                r_levels;
    logic [rpq_pkg::IDX_W-1:0]    r_bg_idx;
    logic [rpq_pkg::COL_W-1:0]    r_columns;
    logic [rpq_pkg::ROW_W-1:0]    r_rows;
    logic [L_W-1:0]               r_lev;
    logic [LVL_W-1:0]             r_lev_m1;
    logic [SQ_W-1:0]              r_lev_sq;

    logic                         cfg_wr;
    rpq_pkg::t_reg_idx            cfg_idx;
    logic [L_W-1:0]               n_lev;

    // Level count clamped to [2, MAX_LEVELS]
    function automatic logic [L_W-1:0] clamp_levels(input logic [CW-1:0] v);
        logic [L_W-1:0] res;
        if (v < CW'(2)) begin
            res = L_W'(2);
        end else if (v > CW'(MAX_LEVELS)) begin
            res = L_W'(MAX_LEVELS);
        end else begin
            res = L_W'(v);
        end
        return res;
    endfunction

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = rpq_pkg::t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;
    assign n_lev   = cfg_wr && (cfg_idx == rpq_pkg::REG_LEVELS)
                   ? clamp_levels(pwdata[CW-1:0])
                   : r_lev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels  <= rpq_pkg::RST_LEVELS;
            r_bg_idx  <= rpq_pkg::RST_BG_IDX;
            r_columns <= rpq_pkg::RST_COLUMNS;
            r_rows    <= rpq_pkg::RST_ROWS;
            r_lev     <= clamp_levels(rpq_pkg::RST_LEVELS);
            r_lev_m1  <= LVL_W'(clamp_levels(rpq_pkg::RST_LEVELS) - L_W'(1));
            r_lev_sq  <= SQ_W'(clamp_levels(rpq_pkg::RST_LEVELS))
                       * SQ_W'(clamp_levels(rpq_pkg::RST_LEVELS));
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx)
                    rpq_pkg::REG_LEVELS:  r_levels  <= pwdata[CW-1:0];
                    rpq_pkg::REG_BG_IDX:  r_bg_idx  <= pwdata[rpq_pkg::IDX_W-1:0];
                    rpq_pkg::REG_COLUMNS: r_columns <= pwdata[rpq_pkg::COL_W-1:0];
                    rpq_pkg::REG_ROWS:    r_rows    <= pwdata[rpq_pkg::ROW_W-1:0];
                    default: ;
                endcase
            end
            // small constant-range product, only changes on a level write
            r_lev    <= n_lev;
            r_lev_m1 <= LVL_W'(n_lev - L_W'(1));
            r_lev_sq <= SQ_W'(n_lev) * SQ_W'(n_lev);
        end
    end

    always_comb begin
        unique case (cfg_idx)
            rpq_pkg::REG_LEVELS:  prdata = rpq_pkg::DATA_W'(r_levels);
            rpq_pkg::REG_BG_IDX:  prdata = rpq_pkg::DATA_W'(r_bg_idx);
            rpq_pkg::REG_COLUMNS: prdata = rpq_pkg::DATA_W'(r_columns);
            rpq_pkg::REG_ROWS:    prdata = rpq_pkg::DATA_W'(r_rows);
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipe control: every stage advances together unless a finished
    // result sits on the output and the sink stalls it.
    // ------------------------------------------------------------------
    logic en;
    logic r_v1, r_v2, r_v3, r_v4;

    assign en          = !(r_v4 && i_cell_stall);
    assign o_pix_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_pix_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: clip against the screen. Usable pixel width is half the
    // column count since each pixel covers two cells.
    // ------------------------------------------------------------------
    logic           col_ok;
    logic           row_ok;
    rpq_pkg::t_pos  n_pos1;
    rpq_pkg::t_pos  r_pos1, r_pos2, r_pos3;

    always_comb begin
        col_ok = !i_pixel_column[rpq_pkg::COORD_W-1]
              && (i_pixel_column[rpq_pkg::COL_W-1:0]
                  < {1'b0, r_columns[rpq_pkg::COL_W-1:1]});
        row_ok = !i_pixel_row[rpq_pkg::COORD_W-1]
              && (i_pixel_row[rpq_pkg::COL_W-1:0] < {1'b0, r_rows});
        n_pos1.drawn = col_ok && row_ok;
        n_pos1.row   = i_pixel_row[rpq_pkg::ROW_W-1:0];
        n_pos1.col   = {i_pixel_column[rpq_pkg::COL_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pos1 <= n_pos1;
            r_pos2 <= r_pos1;
            r_pos3 <= r_pos2;
        end
    end

    // ------------------------------------------------------------------
    // Stages 1-2: per-channel scale, divide by 255 and level pair
    // ------------------------------------------------------------------
    logic [LVL_W-1:0] r_lo_lvl, r_hi_lvl, g_lo_lvl, g_hi_lvl, b_lo_lvl, b_hi_lvl;

    rpq_channel #(.LVL_W(LVL_W)) u_ch_red (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_color  (i_red),
        .i_lev_m1 (r_lev_m1),
        .o_lo     (r_lo_lvl),
        .o_hi     (r_hi_lvl)
    );

    rpq_channel #(.LVL_W(LVL_W)) u_ch_green (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_color  (i_green),
        .i_lev_m1 (r_lev_m1),
        .o_lo     (g_lo_lvl),
        .o_hi     (g_hi_lvl)
    );

    rpq_channel #(.LVL_W(LVL_W)) u_ch_blue (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_color  (i_blue),
        .i_lev_m1 (r_lev_m1),
        .o_lo     (b_lo_lvl),
        .o_hi     (b_hi_lvl)
    );

    // ------------------------------------------------------------------
    // Stage 3: index products r*L*L and g*L for both cells
    // ------------------------------------------------------------------
    logic [RP_W-1:0]  r_rp_lo, r_rp_hi;
    logic [GP_W-1:0]  r_gp_lo, r_gp_hi;
    logic [LVL_W-1:0] r_b_lo, r_b_hi;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rp_lo <= RP_W'(r_lo_lvl) * RP_W'(r_lev_sq);
            r_rp_hi <= RP_W'(r_hi_lvl) * RP_W'(r_lev_sq);
            r_gp_lo <= GP_W'(g_lo_lvl) * GP_W'(r_lev);
            r_gp_hi <= GP_W'(g_hi_lvl) * GP_W'(r_lev);
            r_b_lo  <= b_lo_lvl;
            r_b_hi  <= b_hi_lvl;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sum, swap index zero with the background index, zero the
    // fields of a clipped pixel. Lands in the output register.
    // ------------------------------------------------------------------
    function automatic logic [rpq_pkg::IDX_W-1:0] swap_bg(
        input logic [SUM_W-1:0]          id,
        input logic [rpq_pkg::IDX_W-1:0] bg
    );
        logic [rpq_pkg::IDX_W-1:0] res;
        if (id == '0) begin
            res = bg;
        end else if (id == SUM_W'(bg)) begin
            res = '0;
        end else begin
            res = id[rpq_pkg::IDX_W-1:0];
        end
        return res;
    endfunction

    logic [SUM_W-1:0]          sum_lo, sum_hi;
    logic [rpq_pkg::IDX_W-1:0] n_left, n_right;

    always_comb begin
        sum_lo  = SUM_W'(r_rp_lo) + SUM_W'(r_gp_lo) + SUM_W'(r_b_lo);
        sum_hi  = SUM_W'(r_rp_hi) + SUM_W'(r_gp_hi) + SUM_W'(r_b_hi);
        n_left  = r_pos3.drawn ? swap_bg(sum_lo, r_bg_idx) : '0;
        n_right = r_pos3.drawn ? swap_bg(sum_hi, r_bg_idx) : '0;
    end

    logic                      r_drawn;
    logic [rpq_pkg::ROW_W-1:0] r_cell_row;
    logic [rpq_pkg::COL_W-1:0] r_cell_col;
    logic [rpq_pkg::IDX_W-1:0] r_left_idx;
    logic [rpq_pkg::IDX_W-1:0] r_right_idx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_drawn     <= r_pos3.drawn;
            r_cell_row  <= r_pos3.drawn ? r_pos3.row : '0;
            r_cell_col  <= r_pos3.drawn ? r_pos3.col : '0;
            r_left_idx  <= n_left;
            r_right_idx <= n_right;
        end
    end

    assign o_cell_valid       = r_v4;
    assign o_drawn            = r_drawn;
    assign o_cell_row         = r_cell_row;
    assign o_left_cell_column = r_cell_col;
    assign o_left_index       = r_left_idx;
    assign o_right_index      = r_right_idx;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // clipped pixel carries all-zero fields
    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cell_valid && !o_drawn) |->
            (o_cell_row == '0 && o_left_cell_column == '0
             && o_left_index == '0 && o_right_index == '0))
        else $error("clipped result has nonzero fields");

    // left cell column is always even
    a_col_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cell_valid |-> !o_left_cell_column[0])
        else $error("odd left cell column");

    // a drawn row lies inside the configured screen
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cell_valid && o_drawn) |-> (o_cell_row < r_rows))
        else $error("drawn row outside screen");

    // a stalled result holds the pipe: stage 3 contents do not move
    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix_stall |=> ($stable(r_v3) && $stable(r_pos3)))
        else $error("pipe moved under output stall");

endmodule

### tb/tb_rgb_palette_quantize_two_cell.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_palette_quantize_two_cell
// Self-checking bench for the two-cell palette quantizer. Pixels go in through
// a valid/stall channel with random gaps, results come back under random
// stalls. Each one is checked against a predictor kept in a small scoreboard.
// The register set is reprogrammed between bursts, extremes included.
// ----------------------------------------------------------------------------
module tb_rgb_palette_quantize_two_cell;

    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 170;

    // One expected or observed result transaction
    typedef struct packed {
        logic                      drawn;
        logic [rpq_pkg::ROW_W-1:0] row;
        logic [rpq_pkg::COL_W-1:0] col;
        logic [rpq_pkg::IDX_W-1:0] left;
        logic [rpq_pkg::IDX_W-1:0] right;
    } t_cell;

    // ------------------------------------------------------------------------
    // Scoreboard: register copy, cell predictor, in-order result queue
    // ------------------------------------------------------------------------
    class cell_scoreboard;
        t_cell                         pending_cells[$];
        int                            mismatch_count;
        logic [rpq_pkg::CFG_LEV_W-1:0] levels;
        logic [rpq_pkg::IDX_W-1:0]     bg_index;
        logic [rpq_pkg::COL_W-1:0]     columns;
        logic [rpq_pkg::ROW_W-1:0]     rows;

        function new();
            levels         = rpq_pkg::RST_LEVELS;
            bg_index       = rpq_pkg::RST_BG_IDX;
            columns        = rpq_pkg::RST_COLUMNS;
            rows           = rpq_pkg::RST_ROWS;
            mismatch_count = 0;
        endfunction

        function void set_reg(rpq_pkg::t_reg_idx idx, logic [rpq_pkg::DATA_W-1:0] value);
            case (idx)
                rpq_pkg::REG_LEVELS:  levels   = value[rpq_pkg::CFG_LEV_W-1:0];
                rpq_pkg::REG_BG_IDX:  bg_index = value[rpq_pkg::IDX_W-1:0];
                rpq_pkg::REG_COLUMNS: columns  = value[rpq_pkg::COL_W-1:0];
                rpq_pkg::REG_ROWS:    rows     = value[rpq_pkg::ROW_W-1:0];
                default: ;
            endcase
        endfunction

        // Scale one channel to lev levels; the remainder picks the dither pair
        function void level_pair(input int c, input int lev, output int lo, output int hi);
            int scaled;
            int q;
            int rem;
            scaled = c * (lev - 1);
            q      = scaled / rpq_pkg::CHANNEL_MAX;
            rem    = scaled - q * rpq_pkg::CHANNEL_MAX;
            if (rem < rpq_pkg::LOW_EDGE) begin
                lo = q;
                hi = q;
            end else if (rem >= rpq_pkg::HIGH_EDGE) begin
                lo = q + 1;
                hi = q + 1;
            end else begin
                lo = q;
                hi = q + 1;
            end
        endfunction

        // Cube index with slot zero and the background slot exchanged
        function int palette_slot(int r, int g, int b, int lev);
            int id;
            id = r * lev * lev + g * lev + b;
            if (id == 0)
                id = int'(bg_index);
            else if (id == int'(bg_index))
                id = 0;
            return id & 'hFFF;
        endfunction

        function t_cell quantize_pixel(logic signed [rpq_pkg::COORD_W-1:0] px,
                                       logic signed [rpq_pkg::COORD_W-1:0] py,
                                       logic [rpq_pkg::COLOR_W-1:0] r,
                                       logic [rpq_pkg::COLOR_W-1:0] g,
                                       logic [rpq_pkg::COLOR_W-1:0] b);
            t_cell c;
            int    col_i;
            int    row_i;
            int    max_col;
            int    max_row;
            int    lev;
            int    twice;
            int    rl, rh, gl, gh, bl, bh;
            c       = '0;
            col_i   = int'(px);
            row_i   = int'(py);
            max_col = int'(columns) / 2;
            max_row = int'(rows);
            if (col_i < 0 || col_i >= max_col || row_i < 0 || row_i >= max_row)
                return c;
            lev = int'(levels);
            if (lev < 2)
                lev = 2;
            if (lev > rpq_pkg::MAX_LEVELS_DEF)
                lev = rpq_pkg::MAX_LEVELS_DEF;
            level_pair(int'(r), lev, rl, rh);
            level_pair(int'(g), lev, gl, gh);
            level_pair(int'(b), lev, bl, bh);
            twice   = col_i * 2;
            c.drawn = 1'b1;
            c.row   = row_i[rpq_pkg::ROW_W-1:0];
            c.col   = twice[rpq_pkg::COL_W-1:0];
            c.left  = rpq_pkg::IDX_W'(palette_slot(rl, gl, bl, lev));
            c.right = rpq_pkg::IDX_W'(palette_slot(rh, gh, bh, lev));
            return c;
        endfunction

        function void note_pixel(logic [rpq_pkg::COORD_W-1:0] px,
                                 logic [rpq_pkg::COORD_W-1:0] py,
                                 logic [rpq_pkg::COLOR_W-1:0] r,
                                 logic [rpq_pkg::COLOR_W-1:0] g,
                                 logic [rpq_pkg::COLOR_W-1:0] b);
            pending_cells.push_back(quantize_pixel(px, py, r, g, b));
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_cell(t_cell got);
            t_cell want;
            if (pending_cells.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                mismatch_count++;
                return;
            end
            want = pending_cells.pop_front();
            compare_field("drawn", int'(want.drawn), int'(got.drawn));
            compare_field("cell_row", int'(want.row), int'(got.row));
            compare_field("left_cell_column", int'(want.col), int'(got.col));
            compare_field("left_index", int'(want.left), int'(got.left));
            compare_field("right_index", int'(want.right), int'(got.right));
        endfunction

        function int pending_count();
            return pending_cells.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [rpq_pkg::ADDR_W-1:0]    paddr;
    logic [rpq_pkg::DATA_W-1:0]    pwdata;
    logic [rpq_pkg::DATA_W-1:0]    prdata;
    logic                          pready;
    logic                          i_pix_valid;
    logic                          o_pix_stall;
    logic [rpq_pkg::COORD_W-1:0]   i_pixel_column;
    logic [rpq_pkg::COORD_W-1:0]   i_pixel_row;
    logic [rpq_pkg::COLOR_W-1:0]   i_red;
    logic [rpq_pkg::COLOR_W-1:0]   i_green;
    logic [rpq_pkg::COLOR_W-1:0]   i_blue;
    logic                          o_cell_valid;
    logic                          i_cell_stall;
    logic                          o_drawn;
    logic [rpq_pkg::ROW_W-1:0]     o_cell_row;
    logic [rpq_pkg::COL_W-1:0]     o_left_cell_column;
    logic [rpq_pkg::IDX_W-1:0]     o_left_index;
    logic [rpq_pkg::IDX_W-1:0]     o_right_index;

    cell_scoreboard sb;

    // calm = stretch with no idling on either side
    bit calm       = 1'b0;
    int stall_run  = 0;
    bit stall_on   = 1'b0;

    rgb_palette_quantize_two_cell DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_pix_valid        (i_pix_valid),
        .o_pix_stall        (o_pix_stall),
        .i_pixel_column     (i_pixel_column),
        .i_pixel_row        (i_pixel_row),
        .i_red              (i_red),
        .i_green            (i_green),
        .i_blue             (i_blue),
        .o_cell_valid       (o_cell_valid),
        .i_cell_stall       (i_cell_stall),
        .o_drawn            (o_drawn),
        .o_cell_row         (o_cell_row),
        .o_left_cell_column (o_left_cell_column),
        .o_left_index       (o_left_index),
        .o_right_index      (o_right_index)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: well above the slowest legal run of long gaps and stalls
    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random stall bursts, mostly short, a few long.
    // Stall is held low during calm stretches.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            if (calm) begin
                stall_on  = 1'b0;
                stall_run = 4;
            end else if ($urandom_range(0, 2) == 0) begin
                stall_on  = 1'b1;
                stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                        : $urandom_range(1, 3);
            end else begin
                stall_on  = 1'b0;
                stall_run = $urandom_range(1, 6);
            end
        end else begin
            stall_run = stall_run - 1;
        end
        i_cell_stall <= stall_on;
    end

    // Result monitor: one check per accepted result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_cell_valid && !i_cell_stall)
            sb.check_cell({o_drawn, o_cell_row, o_left_cell_column,
                           o_left_index, o_right_index});
    end

    // ------------------------------------------------------------------------
    // Drivers. Every task is entered right after a rising edge, so all
    // inputs change by nonblocking assignment at the edge.
    // ------------------------------------------------------------------------

    // Register write: setup, then access until pready
    task automatic apb_write(rpq_pkg::t_reg_idx idx, logic [rpq_pkg::DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic write_config(int lev, int bg, int cols, int rows);
        apb_write(rpq_pkg::REG_LEVELS, rpq_pkg::DATA_W'(lev));
        apb_write(rpq_pkg::REG_BG_IDX, rpq_pkg::DATA_W'(bg));
        apb_write(rpq_pkg::REG_COLUMNS, rpq_pkg::DATA_W'(cols));
        apb_write(rpq_pkg::REG_ROWS, rpq_pkg::DATA_W'(rows));
    endtask

    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // One pixel transaction; valid stays high into the next one unless a gap follows
    task automatic send_pixel(logic [rpq_pkg::COORD_W-1:0] px,
                              logic [rpq_pkg::COORD_W-1:0] py,
                              logic [rpq_pkg::COLOR_W-1:0] r,
                              logic [rpq_pkg::COLOR_W-1:0] g,
                              logic [rpq_pkg::COLOR_W-1:0] b);
        int gap;
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        gap = pick_gap();
        if (gap > 0) begin
            i_pix_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_pix_valid    <= 1'b1;
        i_pixel_column <= px;
        i_pixel_row    <= py;
        i_red          <= r;
        i_green        <= g;
        i_blue         <= b;
        @(posedge i_clk);
        while (o_pix_stall) @(posedge i_clk);
        sb.note_pixel(px, py, r, g, b);
    endtask

    // Close a burst and wait for every result: block is idle afterwards
    task automatic drain();
        i_pix_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_count() != 0) @(posedge i_clk);
    endtask

    // Mostly on screen, some edges just inside and outside, some anywhere
    function automatic logic [rpq_pkg::COORD_W-1:0] pick_coord(int span);
        case ($urandom_range(0, 9)) inside
            0, 1: return rpq_pkg::COORD_W'($urandom);
            2: begin
                case ($urandom_range(0, 3))
                    0: return rpq_pkg::COORD_W'(-1);
                    1: return '0;
                    2: return rpq_pkg::COORD_W'(span - 1);
                    default: return rpq_pkg::COORD_W'(span);
                endcase
            end
            default: return (span > 0) ? rpq_pkg::COORD_W'($urandom_range(0, span - 1))
                                       : '0;
        endcase
    endfunction

    function automatic logic [rpq_pkg::COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return rpq_pkg::COLOR_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int lev, bg, cols, rows, cube;
        sb = new();
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        i_pix_valid    <= 1'b0;
        i_pixel_column <= '0;
        i_pixel_row    <= '0;
        i_red          <= '0;
        i_green        <= '0;
        i_blue         <= '0;
        i_cell_stall   <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset config (6 levels, 40x24 pixels, background 0)
        send_pixel(0, 0, 0, 0, 0);
        send_pixel(39, 23, 255, 255, 255);
        send_pixel(40, 0, 10, 20, 30);              // right edge, clipped
        send_pixel(0, 24, 10, 20, 30);              // bottom edge, clipped
        send_pixel(-1, 5, 200, 100, 50);            // negative column
        send_pixel(5, -1, 200, 100, 50);            // negative row
        send_pixel(-2048, -2048, 255, 0, 255);
        send_pixel(2047, 2047, 0, 255, 0);
        send_pixel(10, 10, 12, 13, 38);             // remainders around low/high edge
        send_pixel(11, 11, 39, 12, 13);
        send_pixel(20, 5, 38, 39, 255);
        send_pixel(1, 1, 128, 64, 192);
        send_pixel(38, 22, 255, 0, 0);
        send_pixel(0, 23, 0, 255, 0);
        send_pixel(39, 0, 0, 0, 255);
        send_pixel(12'h555, 12'hAAA, 8'h55, 8'hAA, 8'h0F);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            case (p)
                // two levels, whole cube 0..7 collides with background 1
                0: write_config(2, 1, 2047, 1023);
                // max levels, background at the last palette slot, one pixel column
                1: write_config(16, 4095, 2, 1);
                // level count below range, no rows: all clipped
                2: write_config(0, 4095, 3, 0);
                // level count 1, one column: all clipped
                3: write_config(1, 5, 1, 1023);
                // level count far above range, zero columns
                4: write_config(31, 100, 0, 5);
                5: write_config(17, 0, 2046, 1);
                default: begin
                    lev = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(2, 16);
                    cube = (lev < 2) ? 8 : (lev > 16) ? 4096 : lev * lev * lev;
                    bg = $urandom_range(0, 1) ? $urandom_range(0, cube - 1)
                                              : $urandom_range(0, 4095);
                    case ($urandom_range(0, 4)) inside
                        0:       cols = $urandom_range(0, 3);
                        1, 2:    cols = $urandom_range(2, 80);
                        default: cols = $urandom_range(0, 2047);
                    endcase
                    rows = $urandom_range(0, 1) ? $urandom_range(1, 40)
                                                : $urandom_range(0, 1023);
                    write_config(lev, bg, cols, rows);
                end
            endcase
            @(posedge i_clk);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_pixel(pick_coord(int'(sb.columns) / 2), pick_coord(int'(sb.rows)),
                           pick_color(), pick_color(), pick_color());
        end

        drain();
        // pipe is 4 deep; a few spare cycles catch any stray result
        repeat (8) @(posedge i_clk);
        if (sb.mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
